FILE: src/dcha_pkg.sv
// Shared widths, reset values, codes and controller/datapath interface types.
package dcha_pkg;

  localparam int SIZE_W   = 10;
  localparam int OFF_W    = 4;
  localparam int POS_W    = 16;
  localparam int NUM_W    = 18;
  localparam int IDX_W    = 4;
  localparam int PLANE_W  = 3;
  localparam int CELL_W   = 15;
  localparam int CHG_W    = 24;
  localparam int TIME_W   = 32;
  localparam int STEP_W   = 16;
  localparam int ENERGY_W = 16;
  localparam int KIND_W   = 2;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  localparam logic [SIZE_W-1:0] CELL_WIDTH_RST    = 10'd126;
  localparam logic [SIZE_W-1:0] CELL_HEIGHT_RST   = 10'd123;
  localparam logic [OFF_W-1:0]  COLUMN_OFFSET_RST = 4'd6;
  localparam logic [OFF_W-1:0]  ROW_OFFSET_RST    = 4'd5;

  typedef enum logic [1:0] {
    REG_CELL_WIDTH    = 2'd0,
    REG_CELL_HEIGHT   = 2'd1,
    REG_COLUMN_OFFSET = 2'd2,
    REG_ROW_OFFSET    = 2'd3
  } reg_idx_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_POINT = 2'd0,
    KIND_HIT   = 2'd1,
    KIND_OVF   = 2'd2,
    KIND_EMPTY = 2'd3
  } kind_t;

  typedef struct packed {
    logic  load;
    logic  acc;
    logic  div_start;
    logic  scan_clr;
    logic  scan_go;
    logic  find;
    logic  merge_wr;
    logic  append_wr;
    logic  fill_clr;
    logic  run_clr;
    logic  emit;
    kind_t emit_kind;
    logic  emit_last;
  } dp_cmd_t;

  typedef struct packed {
    logic leave;
    logic run_nz;
    logic div_done;
    logic hit_now;
    logic miss;
    logic pend;
    logic scan_more;
    logic full;
  } dp_stat_t;

endpackage

FILE: src/dcha_ram.sv
// Generic simple dual-port RAM with registered read.
module dcha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/dcha_div.sv
// Restoring divider giving a quotient saturated to 0..15, one bit per cycle.
module dcha_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [dcha_pkg::NUM_W-1:0]   num,
  input  logic [dcha_pkg::SIZE_W-1:0]  den,
  output logic                         done,
  output logic [dcha_pkg::IDX_W-1:0]   quo
);
  import dcha_pkg::*;

  localparam int REM_W = NUM_W - 1;

  logic              run_r;
  logic [2:0]        k_r;
  logic [REM_W-1:0]  rem_r;
  logic [SIZE_W-1:0] den_r;
  logic              neg_r;
  logic              sat_r;
  logic [IDX_W-1:0]  q_r;
  logic [REM_W-1:0]  trial;
  logic              ge;

  assign trial = REM_W'(den_r) << k_r;
  assign ge    = rem_r >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else if (start) begin
      run_r <= 1'b1;
    end else if (run_r && k_r == 3'd0) begin
      run_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      k_r   <= 3'd4;
      rem_r <= num[REM_W-1:0];
      den_r <= den;
      neg_r <= num[NUM_W-1];
      sat_r <= 1'b0;
      q_r   <= '0;
    end else if (run_r) begin
      if (k_r == 3'd4) begin
        sat_r <= ge;
      end else begin
        if (ge) begin
          rem_r <= rem_r - trial;
        end
        q_r[k_r[1:0]] <= ge;
      end
      if (k_r != 3'd0) begin
        k_r <= k_r - 3'd1;
      end
    end
  end

  assign done = !run_r;
  assign quo  = neg_r ? '0 : (sat_r ? '1 : q_r);

endmodule

FILE: src/dcha_ctrl.sv
// Sequencing state machine for steps, table search and end-of-event readout.
module dcha_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               in_command,
  input  dcha_pkg::dp_stat_t stat,
  output dcha_pkg::dp_cmd_t  cmd,
  output logic               busy
);
  import dcha_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_CHK,
    ST_DIVW,
    ST_SEARCH,
    ST_OVF,
    ST_DUMP
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (in_command) begin
            cmd.scan_clr = 1'b1;
            state_nxt    = ST_DUMP;
          end else begin
            state_nxt = ST_ACC;
          end
        end
      end
      ST_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (stat.leave && stat.run_nz) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIVW;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIVW: begin
        if (stat.div_done) begin
          cmd.scan_clr = 1'b1;
          state_nxt    = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd.scan_go   = 1'b1;
        cmd.find      = 1'b1;
        cmd.emit_kind = KIND_POINT;
        if (stat.hit_now) begin
          cmd.merge_wr  = 1'b1;
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          cmd.run_clr   = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (stat.miss) begin
          cmd.emit = 1'b1;
          if (stat.full) begin
            state_nxt = ST_OVF;
          end else begin
            cmd.append_wr = 1'b1;
            cmd.emit_last = 1'b1;
            cmd.run_clr   = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end
      end
      ST_OVF: begin
        cmd.emit      = 1'b1;
        cmd.emit_kind = KIND_OVF;
        cmd.emit_last = 1'b1;
        cmd.run_clr   = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_DUMP: begin
        cmd.scan_go = 1'b1;
        if (stat.pend) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_HIT;
          cmd.emit_last = !stat.scan_more;
          if (!stat.scan_more) begin
            cmd.fill_clr = 1'b1;
            cmd.run_clr  = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end else if (!stat.scan_more) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_EMPTY;
          cmd.emit_last = 1'b1;
          cmd.fill_clr  = 1'b1;
          cmd.run_clr   = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != ST_IDLE);
    end
  end

  assign busy = busy_r;

  a_busy_from_request: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy_r) |-> $past(start))
    else $error("busy rose without a request");

  a_ovf_after_search: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.emit_kind == KIND_OVF) |-> $past(state_r) == ST_SEARCH)
    else $error("overflow issued outside a table search");

endmodule

FILE: src/dcha_dp.sv
// Datapath: running sums, cell index dividers, hit table and result registers.
module dcha_dp #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  dcha_pkg::dp_cmd_t                    cmd,
  output dcha_pkg::dp_stat_t                   stat,
  input  logic [dcha_pkg::SIZE_W-1:0]          cell_width,
  input  logic [dcha_pkg::SIZE_W-1:0]          cell_height,
  input  logic [dcha_pkg::OFF_W-1:0]           column_offset,
  input  logic [dcha_pkg::OFF_W-1:0]           row_offset,
  input  logic                                 in_entering,
  input  logic                                 in_leaving,
  input  logic [dcha_pkg::PLANE_W-1:0]         in_plane,
  input  logic signed [dcha_pkg::POS_W-1:0]    in_pos_x,
  input  logic signed [dcha_pkg::POS_W-1:0]    in_pos_y,
  input  logic [dcha_pkg::ENERGY_W-1:0]        in_energy_deposit,
  input  logic [dcha_pkg::TIME_W-1:0]          in_step_time,
  output logic                                 out_valid,
  output logic [dcha_pkg::KIND_W-1:0]          out_kind,
  output logic [dcha_pkg::CELL_W-1:0]          out_cell_id,
  output logic [dcha_pkg::CHG_W-1:0]           out_charge,
  output logic [dcha_pkg::TIME_W-1:0]          out_hit_time,
  output logic [dcha_pkg::STEP_W-1:0]          out_step_total,
  output logic                                 out_last
);
  import dcha_pkg::*;

  localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int FW     = $clog2(TABLE_DEPTH + 1);
  localparam int PROD_W = SIZE_W + OFF_W;
  localparam logic [FW-1:0] FILL_MAX = FW'(TABLE_DEPTH);

  typedef struct packed {
    logic [CELL_W-1:0] cell_key;
    logic [CHG_W-1:0]  charge;
    logic [TIME_W-1:0] earliest;
  } hit_entry_t;

  function automatic logic [CHG_W-1:0] sat_add(input logic [CHG_W-1:0] a,
                                               input logic [CHG_W-1:0] b);
    logic [CHG_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CHG_W] ? '1 : s[CHG_W-1:0];
  endfunction

  logic                       entering_r;
  logic                       leaving_r;
  logic [PLANE_W-1:0]         plane_r;
  logic signed [POS_W-1:0]    pos_x_r;
  logic signed [POS_W-1:0]    pos_y_r;
  logic [ENERGY_W-1:0]        energy_r;
  logic [TIME_W-1:0]          time_r;

  logic [CHG_W-1:0]           run_charge_r;
  logic [STEP_W-1:0]          steps_r;
  logic [TIME_W-1:0]          entry_r;
  logic [CHG_W-1:0]           charge_base;
  logic [STEP_W-1:0]          steps_base;

  logic [SIZE_W-1:0]          w_eff;
  logic [SIZE_W-1:0]          h_eff;
  logic [PROD_W-1:0]          prod_x;
  logic [PROD_W-1:0]          prod_y;
  logic [NUM_W-1:0]           num_x_r;
  logic [NUM_W-1:0]           num_y_r;
  logic                       done_x;
  logic                       done_y;
  logic [IDX_W-1:0]           col;
  logic [IDX_W-1:0]           row;
  logic [CELL_W-1:0]          cell_id;

  logic [FW-1:0]              fill_r;
  logic [FW-1:0]              scan_r;
  logic                       pend_r;
  logic [AW-1:0]              pend_idx_r;
  logic                       scan_more;
  logic                       hit_now;
  logic                       rd_en;
  logic                       we;
  logic [AW-1:0]              waddr;
  hit_entry_t                 wentry;
  hit_entry_t                 rentry;

  logic                       out_valid_r;
  kind_t                      out_kind_r;
  logic [CELL_W-1:0]          out_cell_r;
  logic [CHG_W-1:0]           out_charge_r;
  logic [TIME_W-1:0]          out_time_r;
  logic [STEP_W-1:0]          out_steps_r;
  logic                       out_last_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      entering_r <= in_entering;
      leaving_r  <= in_leaving;
      plane_r    <= in_plane;
      pos_x_r    <= in_pos_x;
      pos_y_r    <= in_pos_y;
      energy_r   <= in_energy_deposit;
      time_r     <= in_step_time;
    end
  end

  assign charge_base = entering_r ? '0 : run_charge_r;
  assign steps_base  = entering_r ? '0 : steps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_charge_r <= '0;
      steps_r      <= '0;
      entry_r      <= '0;
    end else if (cmd.run_clr) begin
      run_charge_r <= '0;
      steps_r      <= '0;
      entry_r      <= '0;
    end else if (cmd.acc) begin
      run_charge_r <= sat_add(charge_base, CHG_W'(energy_r));
      steps_r      <= (steps_base == '1) ? steps_base : steps_base + STEP_W'(1);
      if (entering_r) begin
        entry_r <= time_r;
      end
    end
  end

  assign w_eff  = (cell_width == '0) ? SIZE_W'(1) : cell_width;
  assign h_eff  = (cell_height == '0) ? SIZE_W'(1) : cell_height;
  assign prod_x = PROD_W'(column_offset) * PROD_W'(w_eff);
  assign prod_y = PROD_W'(row_offset) * PROD_W'(h_eff);

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      num_x_r <= NUM_W'(pos_x_r) + NUM_W'(prod_x);
      num_y_r <= NUM_W'(prod_y) - NUM_W'(pos_y_r);
    end
  end

  dcha_div u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num_x_r),
    .den   (w_eff),
    .done  (done_x),
    .quo   (col)
  );

  dcha_div u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num_y_r),
    .den   (h_eff),
    .done  (done_y),
    .quo   (row)
  );

  assign cell_id = {plane_r, 2'b00, col, 2'b00, row};

  assign scan_more = scan_r < fill_r;
  assign hit_now   = pend_r && (rentry.cell_key == cell_id);
  assign rd_en     = cmd.scan_go && scan_more && !(cmd.find && hit_now);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= '0;
      pend_r <= 1'b0;
    end else if (cmd.scan_clr) begin
      scan_r <= '0;
      pend_r <= 1'b0;
    end else if (cmd.scan_go) begin
      pend_r <= rd_en;
      if (rd_en) begin
        scan_r <= scan_r + FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      pend_idx_r <= scan_r[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.fill_clr) begin
      fill_r <= '0;
    end else if (cmd.append_wr) begin
      fill_r <= fill_r + FW'(1);
    end
  end

  assign we    = cmd.merge_wr || cmd.append_wr;
  assign waddr = cmd.merge_wr ? pend_idx_r : fill_r[AW-1:0];

  always_comb begin
    wentry.cell_key = cell_id;
    if (cmd.merge_wr) begin
      wentry.charge   = sat_add(rentry.charge, run_charge_r);
      wentry.earliest = (rentry.earliest > entry_r) ? entry_r : rentry.earliest;
    end else begin
      wentry.charge   = run_charge_r;
      wentry.earliest = entry_r;
    end
  end

  dcha_ram #(
    .WIDTH ($bits(hit_entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wentry),
    .re    (rd_en),
    .raddr (scan_r[AW-1:0]),
    .rdata (rentry)
  );

  always_comb begin
    stat.leave     = leaving_r;
    stat.run_nz    = (run_charge_r != '0);
    stat.div_done  = done_x && done_y;
    stat.hit_now   = hit_now;
    stat.miss      = !pend_r && !scan_more;
    stat.pend      = pend_r;
    stat.scan_more = scan_more;
    stat.full      = (fill_r == FILL_MAX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind_r <= cmd.emit_kind;
      out_last_r <= cmd.emit_last;
      case (cmd.emit_kind)
        KIND_HIT: begin
          out_cell_r   <= rentry.cell_key;
          out_charge_r <= rentry.charge;
          out_time_r   <= rentry.earliest;
          out_steps_r  <= '0;
        end
        KIND_EMPTY: begin
          out_cell_r   <= '0;
          out_charge_r <= '0;
          out_time_r   <= '0;
          out_steps_r  <= '0;
        end
        default: begin
          out_cell_r   <= cell_id;
          out_charge_r <= run_charge_r;
          out_time_r   <= entry_r;
          out_steps_r  <= steps_r;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_cell_id    = out_cell_r;
  assign out_charge     = out_charge_r;
  assign out_hit_time   = out_time_r;
  assign out_step_total = out_steps_r;
  assign out_last       = out_last_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_MAX)
    else $error("hit table fill beyond depth");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(we && rd_en))
    else $error("table write and read in the same cycle");

  a_ovf_follows_point: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_OVF) |->
      ($past(out_valid_r) && $past(out_kind_r) == KIND_POINT && !$past(out_last_r)))
    else $error("overflow result without a preceding point record");

endmodule

FILE: src/detector_cell_hit_accumulator.sv
// Top level: configuration registers, controller and datapath of the cell hit accumulator.
// A step request that leaves no point record keeps busy high in ST_ACC and ST_CHK, and
// a new request is taken only in ST_IDLE. A leaving step runs the cell index dividers, then
// scans one table entry per cycle through the hit table RAM; an overflow adds the ST_OVF state.
// End of event reads one hit entry per cycle from the table RAM.
// Synchronous reset restores the geometry registers and empties the table and running sums.
module detector_cell_hit_accumulator #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_command,
  input  logic                                in_entering,
  input  logic                                in_leaving,
  input  logic [dcha_pkg::PLANE_W-1:0]        in_plane,
  input  logic signed [dcha_pkg::POS_W-1:0]   in_pos_x,
  input  logic signed [dcha_pkg::POS_W-1:0]   in_pos_y,
  input  logic [dcha_pkg::ENERGY_W-1:0]       in_energy_deposit,
  input  logic [dcha_pkg::TIME_W-1:0]         in_step_time,
  output logic                                out_valid,
  output logic [dcha_pkg::KIND_W-1:0]         out_kind,
  output logic [dcha_pkg::CELL_W-1:0]         out_cell_id,
  output logic [dcha_pkg::CHG_W-1:0]          out_charge,
  output logic [dcha_pkg::TIME_W-1:0]         out_hit_time,
  output logic [dcha_pkg::STEP_W-1:0]         out_step_total,
  output logic                                out_last,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dcha_pkg::PADDR_W-1:0]        paddr,
  input  logic [dcha_pkg::PDATA_W-1:0]        pwdata,
  output logic [dcha_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);
  import dcha_pkg::*;

  logic [SIZE_W-1:0] cell_width_r;
  logic [SIZE_W-1:0] cell_height_r;
  logic [OFF_W-1:0]  column_offset_r;
  logic [OFF_W-1:0]  row_offset_r;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;
  dp_cmd_t           cmd;
  dp_stat_t          stat;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_width_r    <= CELL_WIDTH_RST;
      cell_height_r   <= CELL_HEIGHT_RST;
      column_offset_r <= COLUMN_OFFSET_RST;
      row_offset_r    <= ROW_OFFSET_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_CELL_WIDTH:    cell_width_r    <= pwdata[SIZE_W-1:0];
        REG_CELL_HEIGHT:   cell_height_r   <= pwdata[SIZE_W-1:0];
        REG_COLUMN_OFFSET: column_offset_r <= pwdata[OFF_W-1:0];
        REG_ROW_OFFSET:    row_offset_r    <= pwdata[OFF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_CELL_WIDTH:    prdata = PDATA_W'(cell_width_r);
      REG_CELL_HEIGHT:   prdata = PDATA_W'(cell_height_r);
      REG_COLUMN_OFFSET: prdata = PDATA_W'(column_offset_r);
      REG_ROW_OFFSET:    prdata = PDATA_W'(row_offset_r);
      default:           prdata = '0;
    endcase
  end

  dcha_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy)
  );

  dcha_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cell_width        (cell_width_r),
    .cell_height       (cell_height_r),
    .column_offset     (column_offset_r),
    .row_offset        (row_offset_r),
    .in_entering       (in_entering),
    .in_leaving        (in_leaving),
    .in_plane          (in_plane),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_energy_deposit (in_energy_deposit),
    .in_step_time      (in_step_time),
    .out_valid         (out_valid),
    .out_kind          (out_kind),
    .out_cell_id       (out_cell_id),
    .out_charge        (out_charge),
    .out_hit_time      (out_hit_time),
    .out_step_total    (out_step_total),
    .out_last          (out_last)
  );

endmodule
